[sv/ddpid_pkg.sv]
package ddpid_pkg;

    localparam int POSITION_BITS      = 24;
    localparam int GAIN_BITS          = 20;
    localparam int GAIN_FRACTION_BITS = 16;
    localparam int DRIVE_BITS         = 21;
    localparam int DRIVE_FRACTION     = 16;
    localparam int CFG_BITS = (POSITION_BITS > GAIN_BITS) ? POSITION_BITS : GAIN_BITS;

    localparam int E_W   = POSITION_BITS + 1;
    localparam int D_W   = POSITION_BITS + 2;
    localparam int TE_W  = POSITION_BITS + 2;
    localparam int TD_W  = POSITION_BITS + 3;
    localparam int LI_W  = 4;
    localparam int TI_W  = 8;
    localparam int PROD_W = GAIN_BITS + 1 + TD_W;
    localparam int SUM_W  = PROD_W + 3;

    localparam int LAT_INT_LIMIT  = 5;
    localparam int TURN_INT_LIMIT = 100;
    localparam int TURN_GATE      = 50;
    localparam int VOLT_LIMIT     = 12 * (2 ** DRIVE_FRACTION);

    typedef enum logic [2:0] {
        REG_LAT_KP   = 3'd0,
        REG_LAT_KI   = 3'd1,
        REG_LAT_KD   = 3'd2,
        REG_TURN_KP  = 3'd3,
        REG_TURN_KI  = 3'd4,
        REG_TURN_KD  = 3'd5,
        REG_TGT_DIST = 3'd6,
        REG_TGT_TURN = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_BITS-1:0] lat_kp;
        logic [GAIN_BITS-1:0] lat_ki;
        logic [GAIN_BITS-1:0] lat_kd;
        logic [GAIN_BITS-1:0] turn_kp;
        logic [GAIN_BITS-1:0] turn_ki;
        logic [GAIN_BITS-1:0] turn_kd;
    } t_gains;

    typedef struct packed {
        logic signed [E_W-1:0]  e;
        logic signed [D_W-1:0]  d;
        logic signed [LI_W-1:0] li;
        logic signed [TE_W-1:0] te;
        logic signed [TD_W-1:0] td;
        logic signed [TI_W-1:0] ti;
    } t_err;

    typedef struct packed {
        logic prod;
        logic out;
    } t_adv;

    function automatic logic signed [PROD_W-1:0] gain_mul(
        input logic [GAIN_BITS-1:0]   g,
        input logic signed [TD_W-1:0] x
    );
        logic signed [GAIN_BITS:0]  gs;
        logic signed [PROD_W-1:0]   p;
        gs = signed'({1'b0, g});
        p  = gs * x;
        return p;
    endfunction

endpackage

[sv/ddpid_if.sv]
interface ddpid_in_if;
    logic valid;
    logic ready;
    logic signed [ddpid_pkg::POSITION_BITS-1:0] left_position;
    logic signed [ddpid_pkg::POSITION_BITS-1:0] right_position;

    modport source (output valid, output left_position, output right_position, input ready);
    modport sink (input valid, input left_position, input right_position, output ready);
endinterface

interface ddpid_out_if;
    logic valid;
    logic ready;
    logic signed [ddpid_pkg::DRIVE_BITS-1:0] left_drive;
    logic signed [ddpid_pkg::DRIVE_BITS-1:0] right_drive;

    modport source (output valid, output left_drive, output right_drive, input ready);
    modport sink (input valid, input left_drive, input right_drive, output ready);
endinterface

[sv/ddpid_err.sv]
module ddpid_err (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_move,
    input  logic signed [ddpid_pkg::POSITION_BITS-1:0] i_left,
    input  logic signed [ddpid_pkg::POSITION_BITS-1:0] i_right,
    input  logic signed [ddpid_pkg::POSITION_BITS-1:0] i_tdist,
    input  logic signed [ddpid_pkg::POSITION_BITS-1:0] i_tturn,
    output ddpid_pkg::t_err                            o_err
);
    import ddpid_pkg::*;

    localparam logic signed [LI_W-1:0]   LI_HI   = LI_W'(LAT_INT_LIMIT);
    localparam logic signed [LI_W-1:0]   LI_LO   = -LI_W'(LAT_INT_LIMIT);
    localparam logic signed [TI_W-1:0]   TI_HI   = TI_W'(TURN_INT_LIMIT);
    localparam logic signed [TI_W-1:0]   TI_LO   = -TI_W'(TURN_INT_LIMIT);
    localparam logic signed [E_W-1:0]    GATE_HI = E_W'(TURN_GATE);
    localparam logic signed [E_W-1:0]    GATE_LO = -E_W'(TURN_GATE);

    logic signed [E_W-1:0]  r_last_e;
    logic signed [TE_W-1:0] r_last_te;
    logic signed [LI_W-1:0] r_li;
    logic signed [TI_W-1:0] r_ti;
    t_err                   r_err;
    t_err                   n_err;

    logic signed [E_W-1:0]    pos_sum;
    logic signed [E_W-1:0]    pos_adj;
    logic signed [E_W-1:0]    avg;
    logic signed [E_W-1:0]    pos_diff;
    logic signed [E_W:0]      li_sum;
    logic signed [TE_W:0]     ti_sum;

    always_comb begin
        pos_sum  = E_W'(i_left) + E_W'(i_right);
        pos_adj  = pos_sum + E_W'({1'b0, pos_sum[E_W-1]});
        avg      = pos_adj >>> 1;
        pos_diff = E_W'(i_left) - E_W'(i_right);

        n_err.e  = E_W'(i_tdist) - avg;
        n_err.d  = D_W'(n_err.e) - D_W'(r_last_e);
        n_err.te = TE_W'(i_tturn) - TE_W'(pos_diff);
        n_err.td = TD_W'(n_err.te) - TD_W'(r_last_te);

        li_sum = (E_W + 1)'(r_li) + (E_W + 1)'(n_err.e);
        if (li_sum > (E_W + 1)'(LI_HI)) begin
            n_err.li = LI_HI;
        end else if (li_sum < (E_W + 1)'(LI_LO)) begin
            n_err.li = LI_LO;
        end else begin
            n_err.li = LI_W'(li_sum);
        end

        ti_sum = (TE_W + 1)'(r_ti) + (TE_W + 1)'(n_err.te);
        if (!(n_err.e < GATE_HI && n_err.e > GATE_LO)) begin
            n_err.ti = '0;
        end else if (ti_sum > (TE_W + 1)'(TI_HI)) begin
            n_err.ti = TI_HI;
        end else if (ti_sum < (TE_W + 1)'(TI_LO)) begin
            n_err.ti = TI_LO;
        end else begin
            n_err.ti = TI_W'(ti_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_e  <= '0;
            r_last_te <= '0;
            r_li      <= '0;
            r_ti      <= '0;
        end else if (i_move) begin
            r_last_e  <= n_err.e;
            r_last_te <= n_err.te;
            r_li      <= n_err.li;
            r_ti      <= n_err.ti;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move) begin
            r_err <= n_err;
        end
    end

    assign o_err = r_err;

endmodule

[sv/ddpid_mac.sv]
module ddpid_mac (
    input  logic                                    i_clk,
    input  ddpid_pkg::t_adv                         i_adv,
    input  ddpid_pkg::t_err                         i_err,
    input  ddpid_pkg::t_gains                       i_gains,
    output logic signed [ddpid_pkg::DRIVE_BITS-1:0] o_left,
    output logic signed [ddpid_pkg::DRIVE_BITS-1:0] o_right
);
    import ddpid_pkg::*;

    localparam int SHR = (GAIN_FRACTION_BITS >= DRIVE_FRACTION) ?
                         GAIN_FRACTION_BITS - DRIVE_FRACTION : 0;
    localparam int SHL = (GAIN_FRACTION_BITS < DRIVE_FRACTION) ?
                         DRIVE_FRACTION - GAIN_FRACTION_BITS : 0;
    localparam int W   = SUM_W + SHL;
    localparam logic signed [W-1:0] LIM_HI = W'(VOLT_LIMIT);
    localparam logic signed [W-1:0] LIM_LO = -W'(VOLT_LIMIT);

    logic signed [PROD_W-1:0] r_p_lkp, r_p_lki, r_p_lkd;
    logic signed [PROD_W-1:0] r_p_tkp, r_p_tki, r_p_tkd;
    logic signed [DRIVE_BITS-1:0] r_left, r_right;
    logic signed [DRIVE_BITS-1:0] n_left, n_right;

    logic signed [SUM_W-1:0] lat, trn;

    function automatic logic signed [DRIVE_BITS-1:0] to_drive(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [W-1:0] s;
        s = (W'(v) <<< SHL) >>> SHR;
        if (s > LIM_HI) begin
            return DRIVE_BITS'(LIM_HI);
        end else if (s < LIM_LO) begin
            return DRIVE_BITS'(LIM_LO);
        end
        return DRIVE_BITS'(s);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_adv.prod) begin
            r_p_lkp <= gain_mul(i_gains.lat_kp, TD_W'(i_err.e));
            r_p_lki <= gain_mul(i_gains.lat_ki, TD_W'(i_err.li));
            r_p_lkd <= gain_mul(i_gains.lat_kd, TD_W'(i_err.d));
            r_p_tkp <= gain_mul(i_gains.turn_kp, TD_W'(i_err.te));
            r_p_tki <= gain_mul(i_gains.turn_ki, TD_W'(i_err.ti));
            r_p_tkd <= gain_mul(i_gains.turn_kd, TD_W'(i_err.td));
        end
    end

    always_comb begin
        lat = SUM_W'(r_p_lkp) + SUM_W'(r_p_lkd) + SUM_W'(r_p_lki);
        trn = SUM_W'(r_p_tkp) + SUM_W'(r_p_tkd) + SUM_W'(r_p_tki);
        n_left  = to_drive(lat + trn);
        n_right = to_drive(lat - trn);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.out) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

[sv/differential_drive_dual_pid_unit.sv]
// Two PID loops for a differential drive: a lateral loop on the target distance minus the
// average wheel position and a turn loop on the target turn minus the wheel difference,
// mixed into left and right drive voltages in signed Q5.16, saturated at 12 V. The block
// takes one request per cycle unless the output stalls. A request passes the input register,
// the error stage with the only loop, the update of the stored errors and integrals, then a
// product stage and a sum and saturation stage that feeds the output register. Gains and
// targets must be written through the configuration port only while no request is in
// flight; the block itself does not enforce it.
module differential_drive_dual_pid_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ddpid_in_if.sink                            i_req,
    ddpid_out_if.source                         o_rsp,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_idx,
    input  logic [ddpid_pkg::CFG_BITS-1:0]      i_cfg_data
);
    import ddpid_pkg::*;

    t_gains                           r_gains;
    logic signed [POSITION_BITS-1:0]  r_tdist;
    logic signed [POSITION_BITS-1:0]  r_tturn;

    logic signed [POSITION_BITS-1:0]  r_left;
    logic signed [POSITION_BITS-1:0]  r_right;
    logic                             r_v0, r_v1, r_v2, r_v3;
    logic                             load0, load1, load2, load3;
    t_adv                             adv;
    t_err                             err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.lat_kp  <= GAIN_BITS'(655);
            r_gains.lat_ki  <= '0;
            r_gains.lat_kd  <= GAIN_BITS'(197);
            r_gains.turn_kp <= GAIN_BITS'(1311);
            r_gains.turn_ki <= GAIN_BITS'(524);
            r_gains.turn_kd <= GAIN_BITS'(131);
            r_tdist         <= POSITION_BITS'(200);
            r_tturn         <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_LAT_KP:   r_gains.lat_kp  <= i_cfg_data[GAIN_BITS-1:0];
                REG_LAT_KI:   r_gains.lat_ki  <= i_cfg_data[GAIN_BITS-1:0];
                REG_LAT_KD:   r_gains.lat_kd  <= i_cfg_data[GAIN_BITS-1:0];
                REG_TURN_KP:  r_gains.turn_kp <= i_cfg_data[GAIN_BITS-1:0];
                REG_TURN_KI:  r_gains.turn_ki <= i_cfg_data[GAIN_BITS-1:0];
                REG_TURN_KD:  r_gains.turn_kd <= i_cfg_data[GAIN_BITS-1:0];
                REG_TGT_DIST: r_tdist <= i_cfg_data[POSITION_BITS-1:0];
                REG_TGT_TURN: r_tturn <= i_cfg_data[POSITION_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign load3 = !r_v3 || o_rsp.ready;
    assign load2 = !r_v2 || load3;
    assign load1 = !r_v1 || load2;
    assign load0 = !r_v0 || load1;

    assign adv.prod = r_v1 && load2;
    assign adv.out  = r_v2 && load3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (load0) begin
                r_v0 <= i_req.valid;
            end
            if (load1) begin
                r_v1 <= r_v0;
            end
            if (load2) begin
                r_v2 <= r_v1;
            end
            if (load3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load0 && i_req.valid) begin
            r_left  <= i_req.left_position;
            r_right <= i_req.right_position;
        end
    end

    assign i_req.ready = load0;

    ddpid_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_move  (r_v0 && load1),
        .i_left  (r_left),
        .i_right (r_right),
        .i_tdist (r_tdist),
        .i_tturn (r_tturn),
        .o_err   (err)
    );

    ddpid_mac u_mac (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_err   (err),
        .i_gains (r_gains),
        .o_left  (o_rsp.left_drive),
        .o_right (o_rsp.right_drive)
    );

    assign o_rsp.valid = r_v3;

endmodule
